FILE: rtl/fractal_gradient_noise_2d_unit_defines.svh
// Assertion macros shared by the fractal gradient noise unit.
// Used by modules that define clk and rst.
`ifndef FRACTAL_GRADIENT_NOISE_2D_UNIT_DEFINES_SVH
`define FRACTAL_GRADIENT_NOISE_2D_UNIT_DEFINES_SVH

// same-cycle implication
`define FGN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FGN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fgn_pkg.sv
// Shared types and constants for the fractal gradient noise unit.
// No dependencies.
`timescale 1ns / 1ps

package fgn_pkg;

  localparam int COORD_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int JOB_W = 36;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST = 2'd1;

  localparam logic [3:0]  OCT_RESET  = 4'd4;
  localparam logic [15:0] PERS_RESET = 16'd32768;
  localparam logic [16:0] AMP_ONE    = 17'd65536;

  // load words carry index in x[7:0] and value in y[7:0]
  typedef struct packed {
    logic               sample;
    logic [3:0]         last_oct;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } fgn_entry_t;

  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic [16:0]             amp;
    logic signed [JOB_W-1:0] prod;
  } fgn_job_t;

endpackage

FILE: rtl/fgn_front.sv
// Front end: configuration registers, input acceptance and word classification.
// Depends on fgn_pkg.
`timescale 1ns / 1ps

module fgn_front #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            func,
  input  logic [7:0]                      perm_index,
  input  logic [7:0]                      perm_value,
  input  logic [23:0]                     sample_x,
  input  logic [23:0]                     sample_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fgn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            full,
  output logic                            push,
  output fgn_pkg::fgn_entry_t             entry,
  output logic [15:0]                     persistence
);
  import fgn_pkg::*;

  logic [3:0] octave_count;
  logic [4:0] n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCT_RESET;
      persistence  <= PERS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OCTAVES: octave_count <= cfg_data[3:0];
        REG_PERSIST: persistence  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (octave_count == 4'd0) n_eff = 5'd1;
    else if (int'(octave_count) > MAX_OCTAVES) n_eff = 5'(MAX_OCTAVES);
    else n_eff = {1'b0, octave_count};
  end

  assign item_ready = !full;
  assign push       = item_valid && !full;

  always_comb begin
    entry.sample   = (func == FUNC_SAMPLE);
    entry.last_oct = 4'(n_eff - 5'd1);
    entry.x        = entry.sample ? sample_x : {16'd0, perm_index};
    entry.y        = entry.sample ? sample_y : {16'd0, perm_value};
  end

endmodule

FILE: rtl/fgn_queue.sv
// Short word queue between the front end and the octave engine.
// Depends on fgn_pkg and the unit defines header.
`timescale 1ns / 1ps
`include "fractal_gradient_noise_2d_unit_defines.svh"

module fgn_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fgn_pkg::fgn_entry_t entry_in,
  output logic                full,
  input  logic                pop,
  output fgn_pkg::fgn_entry_t entry_out,
  output logic                empty
);
  import fgn_pkg::*;

  fgn_entry_t         slots [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `FGN_ASSERT_IMPL(a_no_overflow, push, !full, "queue push while full")
  `FGN_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count slip")

endmodule

FILE: rtl/fgn_octave.sv
// Octave engine: sequences octaves of a sample, holds three copies of the
// permutation table and computes fade, gradients, lerps and weighting.
// Depends on fgn_pkg and the unit defines header.
`timescale 1ns / 1ps
`include "fractal_gradient_noise_2d_unit_defines.svh"

module fgn_octave (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [15:0]         persistence,
  input  fgn_pkg::fgn_entry_t head,
  input  logic                empty,
  output logic                pop,
  output fgn_pkg::fgn_job_t   job
);
  import fgn_pkg::*;

  typedef struct packed {
    logic        valid;
    logic        first;
    logic        last;
    logic [16:0] amp;
  } tag_t;

  function automatic logic [19:0] fade_q(input logic [15:0] t, input logic [31:0] tt);
    logic [36:0] p;
    p = 37'(tt) * 37'd6 + (37'd10 << 32) - ((37'(t) * 37'd15) << 16);
    return p[35:16];
  endfunction

  function automatic logic [16:0] fade_f(input logic [31:0] t3p, input logic [19:0] q);
    logic [36:0] fp;
    fp = 37'(t3p[31:16]) * 37'(q) + 37'd32768;
    return (fp[36:16] > 21'd65536) ? 17'd65536 : fp[32:16];
  endfunction

  function automatic logic signed [18:0] grad(input logic [2:0] h,
                                              input logic signed [17:0] dx,
                                              input logic signed [17:0] dy);
    logic signed [18:0] u, v;
    u = h[2] ? {dy[17], dy} : {dx[17], dx};
    v = h[2] ? {dx[17], dx} : {dy[17], dy};
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic [7:0] tbl_a [0:255];
  logic [7:0] tbl_b [0:255];
  logic [7:0] tbl_c [0:255];

  logic [3:0]  oct;
  logic [16:0] amp;
  logic [32:0] amp_rnd;
  logic        load_go, issue, last_hit;
  logic [23:0] cx, cy;
  logic [7:0]  ix, iy;
  tag_t        tg [1:7];

  assign last_hit = (oct == head.last_oct);
  assign load_go  = !empty && !head.sample && !tg[1].valid;
  assign issue    = !empty && head.sample && adv;
  assign pop      = load_go || (issue && last_hit);
  assign amp_rnd  = 33'(amp) * 33'(persistence) + 33'd32768;

  assign cx = 24'(head.x << oct);
  assign cy = 24'(head.y << oct);
  assign ix = cx[23:16];
  assign iy = cy[23:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      oct <= '0;
      amp <= AMP_ONE;
    end else if (issue) begin
      oct <= last_hit ? 4'd0 : oct + 4'd1;
      amp <= last_hit ? AMP_ONE : amp_rnd[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 7; k++) tg[k].valid <= 1'b0;
    end else if (adv) begin
      tg[1] <= '{valid: issue, first: (oct == 4'd0), last: last_hit, amp: amp};
      for (int k = 2; k <= 7; k++) tg[k] <= tg[k-1];
    end
  end

  // stage 1: corner column hashes, squares of fractions
  logic [7:0]  pa0, pa1, s1_iy;
  logic [15:0] s1_fx, s1_fy;
  logic [31:0] s1_ttx, s1_tty;
  logic [7:0]  a_addr, b_addr;

  always_ff @(posedge clk) begin
    if (load_go) tbl_a[head.x[7:0]] <= head.y[7:0];
    if (issue) begin
      pa0 <= tbl_a[ix];
      pa1 <= tbl_a[8'(ix + 8'd1)];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_iy  <= iy;
      s1_fx  <= cx[15:0];
      s1_fy  <= cy[15:0];
      s1_ttx <= cx[15:0] * cx[15:0];
      s1_tty <= cy[15:0] * cy[15:0];
    end
  end

  assign a_addr = pa0 + s1_iy;
  assign b_addr = pa1 + s1_iy;

  // stage 2: corner hashes, fade products
  logic [7:0]  pb0, pb1, pc0, pc1;
  logic [15:0] s2_fx, s2_fy;
  logic [31:0] s2_t3x, s2_t3y;
  logic [19:0] s2_qx, s2_qy;

  always_ff @(posedge clk) begin
    if (load_go) tbl_b[head.x[7:0]] <= head.y[7:0];
    if (adv && tg[1].valid) begin
      pb0 <= tbl_b[a_addr];
      pb1 <= tbl_b[8'(a_addr + 8'd1)];
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) tbl_c[head.x[7:0]] <= head.y[7:0];
    if (adv && tg[1].valid) begin
      pc0 <= tbl_c[b_addr];
      pc1 <= tbl_c[8'(b_addr + 8'd1)];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_fx  <= s1_fx;
      s2_fy  <= s1_fy;
      s2_t3x <= s1_ttx[31:16] * s1_fx;
      s2_t3y <= s1_tty[31:16] * s1_fy;
      s2_qx  <= fade_q(s1_fx, s1_ttx);
      s2_qy  <= fade_q(s1_fy, s1_tty);
    end
  end

  // stage 3: gradients and fade weights
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [18:0] s3_g00, s3_g10, s3_g01, s3_g11;
  logic [16:0]        s3_u, s3_v;

  assign dx0 = $signed({2'b00, s2_fx});
  assign dy0 = $signed({2'b00, s2_fy});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_g00 <= grad(pb0[2:0], dx0, dy0);
      s3_g01 <= grad(pb1[2:0], dx0, dy1);
      s3_g10 <= grad(pc0[2:0], dx1, dy0);
      s3_g11 <= grad(pc1[2:0], dx1, dy1);
      s3_u   <= fade_f(s2_t3x, s2_qx);
      s3_v   <= fade_f(s2_t3y, s2_qy);
    end
  end

  // stage 4/5: lerp along x
  logic signed [19:0] dxa, dxb;
  logic signed [37:0] s4_la, s4_lb, ra, rb;
  logic signed [18:0] s4_g00, s4_g01;
  logic [16:0]        s4_v;
  logic signed [19:0] x1w, x2w;
  logic signed [18:0] s5_x1, s5_x2;
  logic [16:0]        s5_v;

  assign dxa = {s3_g10[18], s3_g10} - {s3_g00[18], s3_g00};
  assign dxb = {s3_g11[18], s3_g11} - {s3_g01[18], s3_g01};

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_la  <= dxa * $signed({1'b0, s3_u});
      s4_lb  <= dxb * $signed({1'b0, s3_u});
      s4_g00 <= s3_g00;
      s4_g01 <= s3_g01;
      s4_v   <= s3_v;
    end
  end

  assign ra  = (s4_la + 38'sd32768) >>> 16;
  assign rb  = (s4_lb + 38'sd32768) >>> 16;
  assign x1w = {s4_g00[18], s4_g00} + ra[19:0];
  assign x2w = {s4_g01[18], s4_g01} + rb[19:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_x1 <= x1w[18:0];
      s5_x2 <= x2w[18:0];
      s5_v  <= s4_v;
    end
  end

  // stage 6/7: lerp along y
  logic signed [19:0] dy_d;
  logic signed [37:0] s6_l, ry;
  logic signed [18:0] s6_x1, s7_n;
  logic signed [19:0] nw;

  assign dy_d = {s5_x2[18], s5_x2} - {s5_x1[18], s5_x1};

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_l  <= dy_d * $signed({1'b0, s5_v});
      s6_x1 <= s5_x1;
    end
  end

  assign ry = (s6_l + 38'sd32768) >>> 16;
  assign nw = {s6_x1[18], s6_x1} + ry[19:0];

  always_ff @(posedge clk) begin
    if (adv) s7_n <= nw[18:0];
  end

  // stage 8: amplitude weighting
  logic signed [36:0] wp;
  logic signed [JOB_W-1:0] job_prod;
  tag_t job_tag;

  assign wp = s7_n * $signed({1'b0, tg[7].amp});

  always_ff @(posedge clk) begin
    if (adv) job_prod <= wp[JOB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) job_tag.valid <= 1'b0;
    else if (adv) job_tag <= tg[7];
  end

  assign job = '{valid: job_tag.valid, first: job_tag.first, last: job_tag.last,
                 amp: job_tag.amp, prod: job_prod};

  `FGN_ASSERT_IMPL(a_pop_nonempty, pop, !empty, "pop from empty queue")
  `FGN_ASSERT_IMPL(a_first_amp, issue && oct == 4'd0, amp == AMP_ONE, "first octave amplitude")

endmodule

FILE: rtl/fgn_norm.sv
// Back end: octave accumulation, pipelined normalizing divider, saturation
// and the result register. Depends on fgn_pkg.
`timescale 1ns / 1ps

module fgn_norm #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  fgn_pkg::fgn_job_t job,
  output logic              adv,
  output logic              result_valid,
  input  logic              result_ready,
  output logic signed [15:0] noise_value
);
  import fgn_pkg::*;

  localparam int LOG_O  = $clog2(MAX_OCTAVES);
  localparam int SUM_W  = JOB_W + 1 + LOG_O;
  localparam int NORM_W = 17 + LOG_O;
  localparam int D_W    = NORM_W + 2;
  localparam int N_W    = SUM_W;
  localparam int QUO_W  = 18;
  localparam int CMP_W  = N_W + D_W;

  assign adv = !(result_valid && !result_ready);

  logic signed [SUM_W-1:0] run_sum, base_sum, cur_sum, a_sum;
  logic [NORM_W-1:0]       run_norm, base_norm, cur_norm, a_norm;
  logic                    a_valid;

  assign base_sum  = job.first ? '0 : run_sum;
  assign base_norm = job.first ? '0 : run_norm;
  assign cur_sum   = base_sum + SUM_W'(job.prod);
  assign cur_norm  = base_norm + NORM_W'(job.amp);

  always_ff @(posedge clk) begin
    if (adv && job.valid) begin
      run_sum  <= cur_sum;
      run_norm <= cur_norm;
    end
    if (adv) begin
      a_sum  <= cur_sum;
      a_norm <= cur_norm;
    end
  end

  // divider pipeline, one quotient bit per stage
  logic             dv_valid [0:QUO_W];
  logic [N_W-1:0]   dv_rem   [0:QUO_W];
  logic [D_W-1:0]   dv_d     [0:QUO_W];
  logic [QUO_W-1:0] dv_q     [0:QUO_W];
  logic             dv_neg   [0:QUO_W];
  logic             dv_ovf   [0:QUO_W];

  logic           p_neg;
  logic [N_W-1:0] p_mag, p_num;
  logic [D_W-1:0] p_d;

  assign p_neg = a_sum[SUM_W-1];
  assign p_mag = p_neg ? N_W'(-a_sum) : N_W'(a_sum);
  assign p_d   = {a_norm, 2'b00};
  assign p_num = p_mag + N_W'(p_d >> 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= p_num;
      dv_d[0]   <= p_d;
      dv_q[0]   <= '0;
      dv_neg[0] <= p_neg;
      dv_ovf[0] <= (p_num >> QUO_W) >= N_W'(p_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      for (int k = 0; k <= QUO_W; k++) dv_valid[k] <= 1'b0;
    end else if (adv) begin
      a_valid     <= job.valid && job.last;
      dv_valid[0] <= a_valid;
      for (int k = 1; k <= QUO_W; k++) dv_valid[k] <= dv_valid[k-1];
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [CMP_W-1:0] sh, rx;
    logic             ge;
    assign sh = CMP_W'(dv_d[k]) << (QUO_W - 1 - k);
    assign rx = CMP_W'(dv_rem[k]);
    assign ge = rx >= sh;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k+1] <= ge ? N_W'(rx - sh) : dv_rem[k];
        dv_q[k+1]   <= dv_q[k] | (ge ? (QUO_W'(1) << (QUO_W - 1 - k)) : '0);
        dv_d[k+1]   <= dv_d[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_ovf[k+1] <= dv_ovf[k];
      end
    end
  end

  localparam logic [QUO_W-1:0] QPOS = QUO_W'(32767);
  localparam logic [QUO_W-1:0] QNEG = QUO_W'(32768);

  logic [QUO_W-1:0]  qv;
  logic signed [15:0] sat;

  assign qv = dv_q[QUO_W];

  always_comb begin
    if (dv_neg[QUO_W]) begin
      if (dv_ovf[QUO_W] || qv > QNEG) sat = -16'sd32768;
      else sat = $signed(16'(16'd0 - qv[15:0]));
    end else begin
      if (dv_ovf[QUO_W] || qv > QPOS) sat = 16'sd32767;
      else sat = $signed(qv[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= dv_valid[QUO_W];
  end

  always_ff @(posedge clk) begin
    if (adv) noise_value <= sat;
  end

endmodule

FILE: rtl/fractal_gradient_noise_2d_unit.sv
// Two-dimensional improved gradient noise summed over octaves (fBm), Q2.14 out.
// A load word waits until the first table-read stage of the octave engine is
// empty, then writes all three table copies. A sample word occupies the octave
// engine for n octaves, n = octave_count clamped to 1..MAX_OCTAVES: the engine
// starts one octave per cycle while the output does not stall, bounded by the
// two read ports of each table copy. From issue to result a sample passes the 8
// octave stages, the accumulate register, the 18-stage divider and the result
// register. The input stays ready while the four-entry queue has room. The table
// must be loaded completely before sampling.
`timescale 1ns / 1ps

module fractal_gradient_noise_2d_unit #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            func,
  input  logic [7:0]                      perm_index,
  input  logic [7:0]                      perm_value,
  input  logic [23:0]                     sample_x,
  input  logic [23:0]                     sample_y,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic signed [15:0]              noise_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fgn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fgn_pkg::*;

  logic        push, full, pop, empty, adv;
  fgn_entry_t  entry_in, head;
  fgn_job_t    job;
  logic [15:0] persistence;

  fgn_front #(.MAX_OCTAVES(MAX_OCTAVES)) u_front (
    .clk, .rst,
    .item_valid, .item_ready,
    .func, .perm_index, .perm_value, .sample_x, .sample_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .full, .push, .entry(entry_in), .persistence
  );

  fgn_queue u_queue (
    .clk, .rst,
    .push, .entry_in, .full,
    .pop, .entry_out(head), .empty
  );

  fgn_octave u_octave (
    .clk, .rst, .adv, .persistence,
    .head, .empty, .pop, .job
  );

  fgn_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm (
    .clk, .rst, .job, .adv,
    .result_valid, .result_ready, .noise_value
  );

endmodule
